>>> design/serial_frame_receiver_defines.svh
// assertion macros shared by the serial frame receiver
`ifndef SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication on clk, disabled while arst_n is low
`define SFR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, disabled while arst_n is low
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sfr_pkg.sv
// types and constants for the serial frame receiver
package sfr_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned IDX_W    = 3;

	localparam logic [BYTE_W-1:0] GUARD_RESET = 8'd128;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_DATA   = 3'd1,
		PH_PARITY = 3'd2,
		PH_STOP1  = 3'd3,
		PH_STOP2  = 3'd4
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_PARITY  = 2'd1,
		ST_STOP    = 2'd2,
		ST_TIMEOUT = 2'd3
	} status_t;

endpackage

>>> design/serial_frame_receiver.sv
// serial frame receiver: start hunt, eight data bits, even parity, two stop bits
// order: a line bit is registered at its transfer, its result is registered at
//   the edge where the bit leaves the input register
// throughput: one line bit per cycle unless stalled (single framing state update)
// reset: arst_n clears phase, counters, error flags and valid bits at once;
//   guard_limit returns to 128
module serial_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: guard_limit
	input  logic                          cfg_wr_en,
	input  logic [sfr_pkg::BYTE_W-1:0]    cfg_wr_data,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [0] data_bit, [7:1] zero
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sfr_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] received_byte
	output logic [sfr_pkg::STATUS_W-1:0]  m_tuser    // [1:0] frame_status
);
	import sfr_pkg::*;
	`include "serial_frame_receiver_defines.svh"

	// configuration register
	logic [BYTE_W-1:0] guard_q;

	// input register
	logic valid_s1;
	logic bit_s1;

	// framing state
	phase_t            phase_q, phase_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [BYTE_W-1:0] shift_q, shift_d;
	logic [BYTE_W-1:0] idle_q, idle_d;
	logic              par_bad_q, par_bad_d;
	logic              stop_bad_q, stop_bad_d;

	// result register
	logic              valid_s2;
	logic [BYTE_W-1:0] byte_s2;
	status_t           status_s2;

	// result of the current bit
	logic              res_valid;
	logic [BYTE_W-1:0] res_byte;
	status_t           res_status;

	logic              advance;
	logic [BYTE_W:0]   seen;
	logic [BYTE_W-1:0] limit;
	logic              timeout;

	// the input bit moves on whenever the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// idle counting while hunting; a zero limit acts as one
	assign seen    = {1'b0, idle_q} + {{BYTE_W{1'b0}}, 1'b1};
	assign limit   = (guard_q == '0) ? {{(BYTE_W-1){1'b0}}, 1'b1} : guard_q;
	assign timeout = (seen >= {1'b0, limit});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q <= GUARD_RESET;
		end else if (cfg_wr_en) begin
			guard_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			bit_s1 <= s_tdata[0];
		end
	end

	// next framing state
	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		shift_d    = shift_q;
		idle_d     = idle_q;
		par_bad_d  = par_bad_q;
		stop_bad_d = stop_bad_q;
		unique case (phase_q)
			PH_DATA: begin
				// bits arrive lsb first
				shift_d = shift_q | (BYTE_W'(bit_s1) << idx_q);
				idx_d   = idx_q + IDX_W'(1);
				if (idx_q == '1) begin
					phase_d = PH_PARITY;
				end
			end
			PH_PARITY: begin
				par_bad_d = (bit_s1 != ^shift_q);
				phase_d   = PH_STOP1;
			end
			PH_STOP1: begin
				stop_bad_d = stop_bad_q | !bit_s1;
				phase_d    = PH_STOP2;
			end
			PH_STOP2: begin
				// frame done, clear everything for the next hunt
				phase_d    = PH_HUNT;
				idx_d      = '0;
				shift_d    = '0;
				idle_d     = '0;
				par_bad_d  = 1'b0;
				stop_bad_d = 1'b0;
			end
			default: begin
				// hunting; unused codes fall back to it
				phase_d = PH_HUNT;
				if (!bit_s1) begin
					phase_d    = PH_DATA;
					idx_d      = '0;
					shift_d    = '0;
					idle_d     = '0;
					par_bad_d  = 1'b0;
					stop_bad_d = 1'b0;
				end else if (timeout) begin
					idle_d = '0;
				end else begin
					idle_d = seen[BYTE_W-1:0];
				end
			end
		endcase
	end

	// result of the current bit
	always_comb begin
		res_valid  = 1'b0;
		res_byte   = '0;
		res_status = ST_OK;
		unique case (phase_q) inside
			PH_DATA, PH_PARITY, PH_STOP1: begin
				res_valid = 1'b0;
			end
			PH_STOP2: begin
				res_valid = 1'b1;
				res_byte  = shift_q;
				// stop error wins over parity error
				if (stop_bad_q || !bit_s1) begin
					res_status = ST_STOP;
				end else if (par_bad_q) begin
					res_status = ST_PARITY;
				end else begin
					res_status = ST_OK;
				end
			end
			default: begin
				res_valid  = bit_s1 && timeout;
				res_status = ST_TIMEOUT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			idx_q      <= '0;
			shift_q    <= '0;
			idle_q     <= '0;
			par_bad_q  <= 1'b0;
			stop_bad_q <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_d;
			idx_q      <= idx_d;
			shift_q    <= shift_d;
			idle_q     <= idle_d;
			par_bad_q  <= par_bad_d;
			stop_bad_q <= stop_bad_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			byte_s2   <= res_byte;
			status_s2 <= res_status;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = byte_s2;
	assign m_tuser  = status_s2;

	// checks
	`SFR_ASSERT_NEXT(a_stop2_gives_result, advance && phase_q == PH_STOP2, valid_s2,
		"second stop bit gave no result")
	`SFR_ASSERT_NEXT(a_last_data_to_parity,
		advance && phase_q == PH_DATA && idx_q == '1, phase_q == PH_PARITY,
		"eighth data bit did not move to parity")
	`SFR_ASSERT_SAME(a_timeout_zero_byte, valid_s2 && status_s2 == ST_TIMEOUT,
		byte_s2 == '0, "timeout result carries a nonzero byte")
	`SFR_ASSERT_SAME(a_empty_input_ready, !valid_s1, s_tready,
		"empty input register not ready")

endmodule
